// ===== hw/rtl/fdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Field-dependent mobility package
// Shared types, codes and constants of the field-dependent mobility block.
// ----------------------------------------------------------------------------
package fdm_pkg;

   localparam int NUM_STAGES = 27;
   localparam int NUM_VERTS  = 3;

   localparam logic [1:0] MARKER_DONOR    = 2'd1;
   localparam logic [1:0] MARKER_ACCEPTOR = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   localparam logic [1:0] CSR_MOBILITY_DONOR    = 2'd0;
   localparam logic [1:0] CSR_MOBILITY_ACCEPTOR = 2'd1;
   localparam logic [1:0] CSR_FIELD_COEFFICIENT = 2'd2;

   localparam logic [31:0] MOBILITY_RESET = 32'd65536;
   localparam logic [15:0] COEF_RESET     = 16'd0;
   localparam logic [31:0] MOBILITY_MAX   = 32'hFFFF_FFFF;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [40:0] TERM_CAP  = 41'h100_0000_0000;
   localparam logic [42:0] SAT_LIMIT = 43'h3_0000_0000;
   localparam logic [34:0] DIV3_RECIP = 35'(((64'd1 << 36) + 64'd2) / 64'd3);

   typedef struct packed {
      logic [1:0]                        marker;
      logic                              last;
      logic [31:0]                       mu;
      logic [NUM_VERTS-1:0][31:0]        field;
      logic [NUM_VERTS-1:0][25:0]        rem;
      logic [NUM_VERTS-1:0][23:0]        root;
      logic [NUM_VERTS-1:0][27:0]        xval;
      logic [NUM_VERTS-1:0][28:0]        yval;
      logic [NUM_VERTS-1:0][30:0]        mant;
      logic [NUM_VERTS-1:0][62:0]        prod;
      logic [NUM_VERTS-1:0][40:0]        term;
      logic [33:0]                       sum;
      logic                              sat;
      logic [51:0]                       part_lo;
      logic [50:0]                       part_hi;
      logic [31:0]                       mobility;
      logic [1:0]                        status;
   } stage_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = val;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [30:0] exp_coef(input int j);
      logic [63:0] c;
      c = isqrt64(64'd1 << 61);
      for (int i = 1; i < j; i++) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

endpackage

// ===== hw/rtl/field_dependent_mobility_top.sv =====
// ----------------------------------------------------------------------------
// Field-dependent mobility top level
// Computes mu * mean(exp(gamma * sqrt(E))) over the three vertices of a
// triangle element in fixed point, one element per transaction.
// ----------------------------------------------------------------------------
// The block is a 27-stage pipeline that accepts one element transaction per
// cycle when the result side does not stall. The depth is set by the 24-step
// square root (three stages), the sixteen chained mantissa multiplies of the
// power-of-two evaluation (one stage each) and the reciprocal divide by
// three. Stages hold their data under backpressure and empty stages fill
// while the output waits.
module field_dependent_mobility_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // region_marker[1:0], field_vertex_a[33:2], field_vertex_b[65:34],
   // field_vertex_c[97:66], zero fill above.
   input  logic [103:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mobility[31:0], status[33:32], zero fill above.
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int N = fdm_pkg::NUM_STAGES;
   localparam int V = fdm_pkg::NUM_VERTS;

   logic [31:0] mob_donor_ff;
   logic [31:0] mob_acceptor_ff;
   logic [15:0] coef_ff;

   fdm_pkg::stage_type pipe_ff [N];
   fdm_pkg::stage_type pipe_in [N];
   logic [N-1:0]       valid_ff;
   logic [N-1:0]       enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         mob_donor_ff    <= fdm_pkg::MOBILITY_RESET;
         mob_acceptor_ff <= fdm_pkg::MOBILITY_RESET;
         coef_ff         <= fdm_pkg::COEF_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            fdm_pkg::CSR_MOBILITY_DONOR:    mob_donor_ff    <= csr_wdata;
            fdm_pkg::CSR_MOBILITY_ACCEPTOR: mob_acceptor_ff <= csr_wdata;
            fdm_pkg::CSR_FIELD_COEFFICIENT: coef_ff         <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      enable[N-1] = !valid_ff[N-1] || rsp_tready;
      for (int i = N - 2; i >= 0; i--) begin
         enable[i] = !valid_ff[i] || enable[i+1];
      end
   end

   assign req_tready = enable[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (enable[i]) begin
               valid_ff[i] <= (i == 0) ? req_tvalid : valid_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (enable[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   always_comb begin
      pipe_in[0]          = '0;
      pipe_in[0].marker   = req_tdata[1:0];
      pipe_in[0].field[0] = req_tdata[33:2];
      pipe_in[0].field[1] = req_tdata[65:34];
      pipe_in[0].field[2] = req_tdata[97:66];
      pipe_in[0].last     = req_tlast;
      pipe_in[0].mu       = (req_tdata[1:0] == fdm_pkg::MARKER_DONOR) ?
                            mob_donor_ff : mob_acceptor_ff;
   end

   for (genvar g = 1; g < N; g++) begin : g_stage
      if (g <= 3) begin : g_sqrt
         always_comb begin
            fdm_pkg::stage_type nxt;
            logic [47:0] radicand;
            logic [27:0] rtrial;
            logic [27:0] trial;
            nxt = pipe_ff[g-1];
            for (int v = 0; v < V; v++) begin
               radicand = {nxt.field[v], 16'd0};
               for (int s = 0; s < 8; s++) begin
                  rtrial = {nxt.rem[v], radicand[47 - 2 * ((g - 1) * 8 + s) -: 2]};
                  trial  = {2'b00, nxt.root[v], 2'b01};
                  if (rtrial >= trial) begin
                     nxt.rem[v]  = 26'(rtrial - trial);
                     nxt.root[v] = {nxt.root[v][22:0], 1'b1};
                  end else begin
                     nxt.rem[v]  = rtrial[25:0];
                     nxt.root[v] = {nxt.root[v][22:0], 1'b0};
                  end
               end
            end
            pipe_in[g] = nxt;
         end
      end else if (g == 4) begin : g_gamma
         always_comb begin
            fdm_pkg::stage_type nxt;
            logic [39:0] gp;
            nxt = pipe_ff[g-1];
            for (int v = 0; v < V; v++) begin
               gp = coef_ff * nxt.root[v];
               nxt.xval[v] = gp[39:12];
            end
            pipe_in[g] = nxt;
         end
      end else if (g == 5) begin : g_log2e
         always_comb begin
            fdm_pkg::stage_type nxt;
            logic [58:0] lp;
            nxt = pipe_ff[g-1];
            for (int v = 0; v < V; v++) begin
               lp = nxt.xval[v] * fdm_pkg::LOG2E_Q30;
               nxt.yval[v] = lp[58:30];
               nxt.mant[v] = 31'h4000_0000;
            end
            pipe_in[g] = nxt;
         end
      end else if (g <= 21) begin : g_exp
         localparam logic [30:0] COEF = fdm_pkg::exp_coef(g - 5);
         always_comb begin
            fdm_pkg::stage_type nxt;
            logic [61:0] mp;
            nxt = pipe_ff[g-1];
            for (int v = 0; v < V; v++) begin
               mp = nxt.mant[v] * COEF;
               if (nxt.yval[v][21 - g]) begin
                  nxt.mant[v] = mp[60:30];
               end
            end
            pipe_in[g] = nxt;
         end
      end else if (g == 22) begin : g_scale
         always_comb begin
            fdm_pkg::stage_type nxt;
            nxt = pipe_ff[g-1];
            for (int v = 0; v < V; v++) begin
               nxt.prod[v] = nxt.mu * nxt.mant[v];
            end
            pipe_in[g] = nxt;
         end
      end else if (g == 23) begin : g_term
         always_comb begin
            fdm_pkg::stage_type nxt;
            logic [12:0] k;
            logic [12:0] sh;
            logic [63:0] p64;
            logic [63:0] t64;
            nxt = pipe_ff[g-1];
            for (int v = 0; v < V; v++) begin
               k   = nxt.yval[v][28:16];
               sh  = 13'(k - 13'd30);
               p64 = {1'b0, nxt.prod[v]};
               if (k <= 13'd30) begin
                  t64 = p64 >> (5'(13'd30 - k));
               end else if (p64 == 64'd0) begin
                  t64 = 64'd0;
               end else if (sh >= 13'd40) begin
                  t64 = {23'd0, fdm_pkg::TERM_CAP};
               end else if (p64 > ({23'd0, fdm_pkg::TERM_CAP} >> sh[5:0])) begin
                  t64 = {23'd0, fdm_pkg::TERM_CAP};
               end else begin
                  t64 = p64 << sh[5:0];
               end
               if (t64 > {23'd0, fdm_pkg::TERM_CAP}) begin
                  t64 = {23'd0, fdm_pkg::TERM_CAP};
               end
               nxt.term[v] = t64[40:0];
            end
            pipe_in[g] = nxt;
         end
      end else if (g == 24) begin : g_sum
         always_comb begin
            fdm_pkg::stage_type nxt;
            logic [42:0] total;
            nxt   = pipe_ff[g-1];
            total = {2'b00, nxt.term[0]} + {2'b00, nxt.term[1]} + {2'b00, nxt.term[2]};
            nxt.sum = total[33:0];
            nxt.sat = (total >= fdm_pkg::SAT_LIMIT);
            pipe_in[g] = nxt;
         end
      end else if (g == 25) begin : g_recip
         always_comb begin
            fdm_pkg::stage_type nxt;
            nxt = pipe_ff[g-1];
            nxt.part_lo = nxt.sum * fdm_pkg::DIV3_RECIP[17:0];
            nxt.part_hi = nxt.sum * fdm_pkg::DIV3_RECIP[34:18];
            pipe_in[g] = nxt;
         end
      end else begin : g_result
         always_comb begin
            fdm_pkg::stage_type nxt;
            logic [69:0] quot;
            nxt  = pipe_ff[g-1];
            quot = {18'd0, nxt.part_lo} + {1'b0, nxt.part_hi, 18'd0};
            if (nxt.marker != fdm_pkg::MARKER_DONOR &&
                nxt.marker != fdm_pkg::MARKER_ACCEPTOR) begin
               nxt.mobility = '0;
               nxt.status   = fdm_pkg::STATUS_INVALID;
            end else if (nxt.sat) begin
               nxt.mobility = fdm_pkg::MOBILITY_MAX;
               nxt.status   = fdm_pkg::STATUS_SATURATED;
            end else begin
               nxt.mobility = quot[67:36];
               nxt.status   = fdm_pkg::STATUS_OK;
            end
            pipe_in[g] = nxt;
         end
      end
   end

   assign rsp_tvalid = valid_ff[N-1];
   assign rsp_tdata  = {6'd0, pipe_ff[N-1].status, pipe_ff[N-1].mobility};
   assign rsp_tlast  = pipe_ff[N-1].last;

endmodule

// ===== hw/rtl/fdm_checker.sv =====
// ----------------------------------------------------------------------------
// Field-dependent mobility checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fdm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:32] == fdm_pkg::STATUS_OK ||
                      rsp_tdata[33:32] == fdm_pkg::STATUS_INVALID ||
                      rsp_tdata[33:32] == fdm_pkg::STATUS_SATURATED))
      else $error("Unknown status code.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33:32] == fdm_pkg::STATUS_INVALID)
         |-> (rsp_tdata[31:0] == 32'd0))
      else $error("Invalid marker with nonzero mobility.");

   a_saturated_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33:32] == fdm_pkg::STATUS_SATURATED)
         |-> (rsp_tdata[31:0] == fdm_pkg::MOBILITY_MAX))
      else $error("Saturated status without maximum mobility.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("Stalled result changed.");

endmodule

bind field_dependent_mobility_top fdm_checker u_fdm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
